/* src/prfd_pkg.sv */
`timescale 1ns / 1ps

package prfd_pkg;

   localparam int unsigned TIME_W   = 48;
   localparam int unsigned COOKIE_W = 32;
   localparam int unsigned WINDOW_W = 27;
   localparam int unsigned STATE_W  = 2;
   localparam int unsigned COUNT_W  = 2;

   localparam int unsigned DEF_MAX_RECONNECTS = 3;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 27'd60000;

   localparam logic [STATE_W-1:0] PATH_INIT     = 2'd0;
   localparam logic [STATE_W-1:0] PATH_NORMAL   = 2'd1;
   localparam logic [STATE_W-1:0] PATH_UNSTABLE = 2'd2;
   localparam logic [STATE_W-1:0] PATH_FAULT    = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0]   now_ms;
      logic [COOKIE_W-1:0] conn_cookie;
      logic                probe_ok;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0] path_state;
      logic [COUNT_W-1:0] recent_reconnects;
      logic               reconnect_seen;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic update;
      logic expire;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic expire_go;
      logic out_free;
   } ctrl_status_type;

endpackage

/* src/prfd_ctrl.sv */
`timescale 1ns / 1ps

module prfd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  prfd_pkg::ctrl_status_type  status,
   output prfd_pkg::ctrl_cmd_type     cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_UPDATE = 2'd1;
   localparam logic [1:0] S_EXPIRE = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.update = (state_ff == S_UPDATE);
   assign cmd.expire = (state_ff == S_EXPIRE);
   assign cmd.finish = (state_ff == S_FINISH) && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            state_in = S_EXPIRE;
         end
         S_EXPIRE: begin
            if (!status.expire_go) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/prfd_datapath.sv */
`timescale 1ns / 1ps

module prfd_datapath #(
   parameter int unsigned MAX_RECONNECTS = prfd_pkg::DEF_MAX_RECONNECTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prfd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output prfd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [prfd_pkg::WINDOW_W-1:0]       csr_wr_data,
   input  prfd_pkg::ctrl_cmd_type              cmd,
   output prfd_pkg::ctrl_status_type           status
);

   localparam int unsigned RING_SIZE = MAX_RECONNECTS + 1;
   localparam int unsigned IDX_W     = $clog2(RING_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SIZE - 1);

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == LAST_IDX) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   logic [prfd_pkg::TIME_W-1:0]   now_ff;
   logic [prfd_pkg::COOKIE_W-1:0] cookie_ff;
   logic                          ok_ff;
   logic [prfd_pkg::COOKIE_W-1:0] last_cookie_ff, last_cookie_in;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [IDX_W-1:0]              tail_ff, tail_in;
   logic                          seen_ff, seen_in;
   logic [prfd_pkg::STATE_W-1:0]  path_ff, path_in;
   logic [prfd_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   prfd_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [prfd_pkg::TIME_W-1:0]   times_ff [RING_SIZE];

   logic                          seen_now;
   logic                          push;
   logic [prfd_pkg::TIME_W-1:0]   tail_time;
   logic [prfd_pkg::TIME_W-1:0]   age;
   logic                          empty;
   logic                          full;
   logic                          normal;
   logic [IDX_W:0]                count_sum;
   logic [IDX_W:0]                count_mod;
   logic [IDX_W+2:0]              count_wide;

   assign seen_now  = (last_cookie_ff != '0) && (last_cookie_ff != cookie_ff);
   assign push      = cmd.update && ok_ff && seen_now;
   assign tail_time = times_ff[tail_ff];
   assign age       = now_ff - tail_time;
   assign empty     = (head_ff == tail_ff);
   assign full      = (next_idx(head_ff) == tail_ff);

   assign status.expire_go = ok_ff && !empty && (now_ff >= tail_time) &&
                             (age >= prfd_pkg::TIME_W'(window_ff));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign normal = (path_ff == prfd_pkg::PATH_INIT) ||
                   (empty && (path_ff == prfd_pkg::PATH_UNSTABLE)) ||
                   (!full && (path_ff == prfd_pkg::PATH_NORMAL));

   assign count_sum  = {1'b0, head_ff} + (IDX_W+1)'(RING_SIZE) - {1'b0, tail_ff};
   assign count_mod  = (count_sum >= (IDX_W+1)'(RING_SIZE)) ?
                       count_sum - (IDX_W+1)'(RING_SIZE) : count_sum;
   assign count_wide = {2'b00, count_mod};

   always_comb begin
      last_cookie_in = last_cookie_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      seen_in        = seen_ff;
      path_in        = path_ff;
      window_in      = window_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (csr_wr_en) begin
         window_in = csr_wr_data;
      end

      if (cmd.update) begin
         seen_in = ok_ff && seen_now;
         if (ok_ff) begin
            last_cookie_in = cookie_ff;
         end
         if (push) begin
            head_in = next_idx(head_ff);
            if (next_idx(head_ff) == tail_ff) begin
               tail_in = next_idx(tail_ff);
            end
         end
      end

      if (cmd.expire && status.expire_go) begin
         tail_in = next_idx(tail_ff);
      end

      if (cmd.finish) begin
         if (!ok_ff) begin
            path_in = prfd_pkg::PATH_FAULT;
         end else if (normal) begin
            path_in = prfd_pkg::PATH_NORMAL;
         end else begin
            path_in = prfd_pkg::PATH_UNSTABLE;
         end
         rsp_data_in.path_state        = path_in;
         rsp_data_in.recent_reconnects = count_wide[1:0];
         rsp_data_in.reconnect_seen    = seen_ff;
         rsp_valid_in                  = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cookie_ff <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         seen_ff        <= 1'b0;
         path_ff        <= prfd_pkg::PATH_INIT;
         window_ff      <= prfd_pkg::WINDOW_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_cookie_ff <= last_cookie_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         seen_ff        <= seen_in;
         path_ff        <= path_in;
         window_ff      <= window_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         now_ff    <= req_data.now_ms;
         cookie_ff <= req_data.conn_cookie;
         ok_ff     <= req_data.probe_ok;
      end
      if (push) begin
         times_ff[head_ff] <= now_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/path_reconnect_flap_detector.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    prfd_pkg::req_type (probe result)
// rsp      out        rsp_valid/rsp_ready    prfd_pkg::rsp_type (path status)
// csr      in         csr_wr_en              csr_wr_data (window in ms)
//
// After an item is accepted, the sequencer runs an update step, an expiry walk and a final step
// that registers the result; the expiry walk checks one ring entry per cycle.
// One item is worked on at a time; the next item is accepted only once the final step is done.
// A new item is accepted while the result waits.
// Reset clears the ring pointers, stored cookie and path state and sets the window to 60000 ms.
// A stalled result holds the sequencer in its final step until rsp_ready is seen.

module path_reconnect_flap_detector #(
   parameter int unsigned MAX_RECONNECTS = prfd_pkg::DEF_MAX_RECONNECTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  prfd_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output prfd_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [prfd_pkg::WINDOW_W-1:0] csr_wr_data
);

   prfd_pkg::ctrl_cmd_type    cmd;
   prfd_pkg::ctrl_status_type status;

   prfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   prfd_datapath #(
      .MAX_RECONNECTS (MAX_RECONNECTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

/* src/prfd_checker.sv */
`timescale 1ns / 1ps

module prfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input prfd_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result item changed while stalled.");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second item accepted while one is in work.");

   a_never_init: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.path_state != prfd_pkg::PATH_INIT)
      else $error("Result reports the init path state.");

   a_seen_not_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reconnect_seen |-> rsp_data.path_state != prfd_pkg::PATH_FAULT)
      else $error("Reconnect reported on a failed probe.");

endmodule

bind path_reconnect_flap_detector prfd_checker u_prfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import prfd_pkg::*;

   localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [COOKIE_W-1:0] COOKIE_MAX = 32'hFFFF_FFFF;
   localparam logic [WINDOW_W-1:0] WINDOW_MAX = 27'h7FF_FFFF;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 262;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      logic                is_window;
      logic [WINDOW_W-1:0] window;
      req_type             probe;
      logic                typed;
      rsp_type             want;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [WINDOW_W-1:0] csr_wr_data = '0;

   logic steady = 1'b0;
   int error_count = 0;
   int quiet_cycles = 0;

   rsp_type status_due[$];
   plan_row_type plan[$];

   // Tracked path state, kept in step with every accepted probe.
   logic [TIME_W-1:0] hist_time[4];
   logic [1:0] hist_head = '0;
   logic [1:0] hist_tail = '0;
   logic [COOKIE_W-1:0] cookie_held = '0;
   logic [STATE_W-1:0] path_now = PATH_INIT;
   logic [WINDOW_W-1:0] window_ms = WINDOW_RESET;

   logic [TIME_W-1:0] clock_ms = '0;
   logic [COOKIE_W-1:0] cookie_sent = '0;

   path_reconnect_flap_detector dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type track_probe(req_type p);
      rsp_type r;
      logic seen;
      logic empty;
      logic full;
      logic [1:0] head_next;
      int n;
      seen = 1'b0;
      if (!p.probe_ok) begin
         path_now = PATH_FAULT;
      end else begin
         seen = (cookie_held != '0) && (cookie_held != p.conn_cookie);
         cookie_held = p.conn_cookie;
         if (seen) begin
            hist_time[hist_head] = p.now_ms;
            hist_head = hist_head + 2'd1;
            if (hist_head == hist_tail) begin
               hist_tail = hist_tail + 2'd1;
            end
         end
         for (n = 0; n < 4; n++) begin
            if (hist_tail == hist_head) break;
            if (p.now_ms < hist_time[hist_tail]) break;
            if (p.now_ms - hist_time[hist_tail] < {21'd0, window_ms}) break;
            hist_tail = hist_tail + 2'd1;
         end
         head_next = hist_head + 2'd1;
         empty = hist_head == hist_tail;
         full = head_next == hist_tail;
         if (path_now == PATH_INIT || (empty && path_now == PATH_UNSTABLE) ||
             (!full && path_now == PATH_NORMAL)) begin
            path_now = PATH_NORMAL;
         end else begin
            path_now = PATH_UNSTABLE;
         end
      end
      r.path_state = path_now;
      r.recent_reconnects = hist_head - hist_tail;
      r.reconnect_seen = seen;
      return r;
   endfunction

   function automatic plan_row_type probe_row(logic [TIME_W-1:0] t, logic [COOKIE_W-1:0] c,
                                              logic ok, logic typed, logic [STATE_W-1:0] st,
                                              logic [COUNT_W-1:0] cnt, logic seen);
      plan_row_type r;
      r.is_window = 1'b0;
      r.window = '0;
      r.probe.now_ms = t;
      r.probe.conn_cookie = c;
      r.probe.probe_ok = ok;
      r.typed = typed;
      r.want.path_state = st;
      r.want.recent_reconnects = cnt;
      r.want.reconnect_seen = seen;
      return r;
   endfunction

   function automatic plan_row_type window_row(logic [WINDOW_W-1:0] w);
      plan_row_type r;
      r = probe_row('0, '0, 1'b0, 1'b0, PATH_INIT, 2'd0, 1'b0);
      r.is_window = 1'b1;
      r.window = w;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= 100) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   task automatic drain_path();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(logic [WINDOW_W-1:0] w);
      drain_path();
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      window_ms = w;
      csr_wr_en <= 1'b0;
   endtask

   task automatic offer_probe(req_type p, logic typed, rsp_type want);
      int gap;
      rsp_type due;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < 28) gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!req_ready);
      due = track_probe(p);
      status_due.push_back(typed ? want : due);
   endtask

   task automatic random_probe(logic [WINDOW_W-1:0] w, output req_type p);
      int pick;
      pick = $urandom_range(99);
      if (pick < 2) begin
         clock_ms = {16'($urandom), 32'($urandom)};
      end else if (pick < 4) begin
         clock_ms = clock_ms - $urandom_range(1000);
      end else if (pick < 14) begin
         clock_ms = clock_ms + $urandom_range(2 * w + 2);
      end else if (pick >= 30) begin
         clock_ms = clock_ms + $urandom_range(w / 3 + 1);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
         cookie_sent = '0;
      end else if (pick < 35) begin
         cookie_sent = $urandom_range(4, 1);
      end else if (pick < 55) begin
         cookie_sent = $urandom;
      end
      p.now_ms = clock_ms;
      p.conn_cookie = cookie_sent;
      p.probe_ok = $urandom_range(99) >= 12;
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin : check_rsp
      rsp_type due;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (status_due.size() == 0) begin
            report_mismatch("result with no probe pending");
         end else begin
            due = status_due.pop_front();
            if (rsp_data.path_state !== due.path_state) begin
               report_mismatch($sformatf("path_state %0d, expected %0d",
                                         rsp_data.path_state, due.path_state));
            end
            if (rsp_data.recent_reconnects !== due.recent_reconnects) begin
               report_mismatch($sformatf("recent_reconnects %0d, expected %0d",
                                         rsp_data.recent_reconnects, due.recent_reconnects));
            end
            if (rsp_data.reconnect_seen !== due.reconnect_seen) begin
               report_mismatch($sformatf("reconnect_seen %0d, expected %0d",
                                         rsp_data.reconnect_seen, due.reconnect_seen));
            end
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [WINDOW_W-1:0] windows[7];
      req_type p;
      rsp_type none;
      int ph;
      int k;
      none = '0;
      foreach (hist_time[i]) hist_time[i] = '0;
      windows = '{27'd60000, 27'd5000, 27'd86400000, 27'd1, 27'd0, WINDOW_MAX, 27'd250};

      plan.push_back(probe_row(48'd0, 32'd0, 1'b1, 1'b1, PATH_NORMAL, 2'd0, 1'b0));
      plan.push_back(probe_row(48'd0, 32'd5, 1'b1, 1'b0, PATH_NORMAL, 2'd0, 1'b0));
      plan.push_back(probe_row(48'd10, 32'd6, 1'b1, 1'b0, PATH_NORMAL, 2'd1, 1'b1));
      plan.push_back(probe_row(48'd20, 32'd7, 1'b1, 1'b0, PATH_NORMAL, 2'd2, 1'b1));
      plan.push_back(probe_row(48'd30, 32'd8, 1'b1, 1'b0, PATH_UNSTABLE, 2'd3, 1'b1));
      plan.push_back(probe_row(48'd40, 32'd9, 1'b1, 1'b0, PATH_UNSTABLE, 2'd3, 1'b1));
      plan.push_back(probe_row(48'd50, 32'd1, 1'b0, 1'b1, PATH_FAULT, 2'd3, 1'b0));
      plan.push_back(probe_row(48'd60060, 32'd9, 1'b1, 1'b0, PATH_UNSTABLE, 2'd0, 1'b0));
      plan.push_back(probe_row(48'd60060, 32'd9, 1'b1, 1'b0, PATH_NORMAL, 2'd0, 1'b0));
      plan.push_back(probe_row(TIME_MAX, COOKIE_MAX, 1'b1, 1'b1, PATH_NORMAL, 2'd1, 1'b1));
      plan.push_back(probe_row(48'd0, 32'd0, 1'b1, 1'b0, PATH_NORMAL, 2'd2, 1'b1));
      plan.push_back(probe_row(48'd0, 32'd3, 1'b1, 1'b0, PATH_NORMAL, 2'd2, 1'b0));
      plan.push_back(probe_row(TIME_MAX, COOKIE_MAX, 1'b0, 1'b1, PATH_FAULT, 2'd2, 1'b0));
      plan.push_back(probe_row(TIME_MAX, 32'd3, 1'b1, 1'b1, PATH_UNSTABLE, 2'd2, 1'b0));
      plan.push_back(window_row(27'd0));
      plan.push_back(probe_row(TIME_MAX, 32'd4, 1'b1, 1'b1, PATH_NORMAL, 2'd0, 1'b1));
      plan.push_back(window_row(27'd1));
      plan.push_back(probe_row(TIME_MAX, 32'd5, 1'b1, 1'b0, PATH_INIT, 2'd0, 1'b0));
      plan.push_back(probe_row(TIME_MAX, 32'd6, 1'b1, 1'b0, PATH_INIT, 2'd0, 1'b0));
      plan.push_back(probe_row(TIME_MAX, 32'd7, 1'b1, 1'b0, PATH_INIT, 2'd0, 1'b0));
      plan.push_back(probe_row(48'd0, 32'd7, 1'b1, 1'b0, PATH_INIT, 2'd0, 1'b0));
      plan.push_back(window_row(WINDOW_MAX));
      plan.push_back(probe_row(48'd100, 32'd8, 1'b1, 1'b0, PATH_INIT, 2'd0, 1'b0));
      plan.push_back(probe_row(48'd134217827, 32'd8, 1'b1, 1'b0, PATH_INIT, 2'd0, 1'b0));
      plan.push_back(probe_row(48'd134217827, 32'd0, 1'b0, 1'b0, PATH_INIT, 2'd0, 1'b0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_window) begin
            set_window(plan[i].window);
         end else begin
            offer_probe(plan[i].probe, plan[i].typed, plan[i].want);
         end
      end

      for (ph = 0; ph < 7; ph++) begin
         set_window(windows[ph]);
         steady <= (ph == 2);
         clock_ms = {16'd0, 32'($urandom_range(1000))};
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99) == 0) begin
               drain_path();
            end
            random_probe(windows[ph], p);
            offer_probe(p, 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
